// ===== rtl/rft_pkg.sv =====
`timescale 1ns / 1ps

package rft_pkg;

  // line store depth and rail limit
  localparam int MAX_LEN   = 64;
  localparam int MAX_RAILS = 16;

  localparam int SYM_W   = 8;
  localparam int ADDR_W  = $clog2(MAX_LEN);
  localparam int LEN_W   = $clog2(MAX_LEN + 1);
  localparam int RAILS_W = $clog2(MAX_RAILS + 1);
  localparam int RAIL_W  = $clog2(MAX_RAILS);
  localparam int STEP_W  = $clog2(2 * MAX_RAILS - 1);

  // configuration port
  localparam int CFG_RAIL_W = 5;
  localparam int CFG_DATA_W = 5;
  localparam int CFG_IDX_W  = 1;

  localparam logic [CFG_IDX_W-1:0]  REG_RAIL_COUNT  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0]  REG_DECODE_MODE = CFG_IDX_W'(1);
  localparam logic [CFG_RAIL_W-1:0] RAIL_RESET      = CFG_RAIL_W'(2);

  typedef logic [SYM_W-1:0] sym_t;

endpackage

// ===== rtl/rft_ram.sv =====
`timescale 1ns / 1ps

module rft_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/rail_fence_line_transposer.sv =====
`timescale 1ns / 1ps

// rail fence transposer for one text line
// input channel (in_*): one symbol word per handshake, in_end_of_line marks
//   the final word of a line; words are written into a 64-entry line store,
//   one per cycle while in_stall is low, words past the store depth are dropped and flagged
// output channel (out_*): the whole line in permuted order, out_last on the
//   final word, out_overflow on every word of a truncated line
// config (cfg_*): index 0 rail count, index 1 decode mode; sampled when the
//   end-of-line word is accepted
// sequence: encode starts reading right after the end-of-line word; each word is
//   one store read followed by one output register load, and the next read
//   waits for that load; decode first runs a permute pass from the line store
//   into a reorder store, then emits from it in the same way
// in_stall is high from the end-of-line word until the last read of the line
//   is issued; a stalled out_* word holds and no further read is issued
// reset: control state cleared, rail count 2, encode mode, line empty;
//   both stores come up with undefined contents, only written entries are read
module rail_fence_line_transposer (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  rft_pkg::sym_t                   in_symbol,
  input  logic                            in_end_of_line,
  output logic                            out_valid,
  input  logic                            out_stall,
  output rft_pkg::sym_t                   out_symbol,
  output logic                            out_last,
  output logic                            out_overflow,
  input  logic                            cfg_we,
  input  logic [rft_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [rft_pkg::CFG_DATA_W-1:0]  cfg_data
);

  import rft_pkg::*;

  localparam logic [1:0] S_LOAD    = 2'd0;
  localparam logic [1:0] S_PERM    = 2'd1;
  localparam logic [1:0] S_PERMEND = 2'd2;
  localparam logic [1:0] S_EMIT    = 2'd3;

  // control and configuration
  logic [1:0]            state_r, state_nxt;
  logic [CFG_RAIL_W-1:0] cfg_rail_r, cfg_rail_nxt;
  logic                  cfg_mode_r, cfg_mode_nxt;
  logic [RAILS_W-1:0]    rails_r, rails_nxt;
  logic                  mode_r, mode_nxt;
  logic [LEN_W-1:0]      len_r, len_nxt;
  logic                  ovf_r, ovf_nxt;
  logic [LEN_W-1:0]      n_r, n_nxt;

  // zigzag walker
  logic [ADDR_W-1:0]     pos_r, pos_nxt;
  logic [RAIL_W-1:0]     rail_r, rail_nxt;
  logic                  phase_r, phase_nxt;

  // read / write pipeline
  logic                  pend_r, pend_nxt;
  logic                  pend_last_r, pend_last_nxt;
  logic                  pend_ovf_r, pend_ovf_nxt;
  logic                  wr_pend_r, wr_pend_nxt;
  logic [ADDR_W-1:0]     wr_addr_r, wr_addr_nxt;

  // output register
  logic                  out_valid_r, out_valid_nxt;
  sym_t                  out_symbol_r, out_symbol_nxt;
  logic                  out_last_r, out_last_nxt;
  logic                  out_ovf_r, out_ovf_nxt;

  // ram ports
  logic                  st_we, st_re;
  logic [ADDR_W-1:0]     st_raddr;
  sym_t                  st_rdata;
  logic                  rb_re;
  sym_t                  rb_rdata;

  logic                  in_accept;
  logic                  issue;
  logic                  at_last;
  logic [RAILS_W-1:0]    eff_rails;
  logic [RAILS_W:0]      period_full;
  logic [STEP_W-1:0]     period, two_k, step_a, step_b, step_sel, step;
  logic [LEN_W:0]        pos_sum;
  logic                  wrap;
  logic [ADDR_W-1:0]     adv_pos;
  logic [RAIL_W-1:0]     adv_rail;
  logic                  adv_phase;

  rft_ram #(.WIDTH(SYM_W), .DEPTH(MAX_LEN)) u_line_store (
    .clk   (clk),
    .we    (st_we),
    .waddr (len_r[ADDR_W-1:0]),
    .wdata (in_symbol),
    .re    (st_re),
    .raddr (st_raddr),
    .rdata (st_rdata)
  );

  // reorder store, filled by the decode permute pass
  rft_ram #(.WIDTH(SYM_W), .DEPTH(MAX_LEN)) u_reorder_store (
    .clk   (clk),
    .we    (wr_pend_r),
    .waddr (wr_addr_r),
    .wdata (st_rdata),
    .re    (rb_re),
    .raddr (n_r[ADDR_W-1:0]),
    .rdata (rb_rdata)
  );

  assign in_stall  = (state_r != S_LOAD);
  assign in_accept = in_valid && !in_stall;
  assign st_we     = in_accept && (len_r < LEN_W'(MAX_LEN));
  assign issue     = (state_r == S_EMIT) && !pend_r && (!out_valid_r || !out_stall);
  assign at_last   = (n_r == len_r - LEN_W'(1));

  // rail count zero acts as one rail, large counts saturate
  always_comb begin
    if (cfg_rail_r == '0) begin
      eff_rails = RAILS_W'(1);
    end else if (RAILS_W'(cfg_rail_r) > RAILS_W'(MAX_RAILS)) begin
      eff_rails = RAILS_W'(MAX_RAILS);
    end else begin
      eff_rails = RAILS_W'(cfg_rail_r);
    end
  end

  // next position on the current rail: steps alternate period-2k and 2k,
  // a zero step (top or bottom rail) becomes a full period
  assign period_full = {rails_r - RAILS_W'(1), 1'b0};
  assign period      = STEP_W'(period_full);
  assign two_k       = STEP_W'({rail_r, 1'b0});
  assign step_a      = period - two_k;
  assign step_b      = two_k;
  assign step_sel    = phase_r ? step_b : step_a;

  always_comb begin
    if (rails_r == RAILS_W'(1)) begin
      step = STEP_W'(1);
    end else if (step_sel == '0) begin
      step = period;
    end else begin
      step = step_sel;
    end
  end

  assign pos_sum = (LEN_W + 1)'(pos_r) + (LEN_W + 1)'(step);
  assign wrap    = (pos_sum >= {1'b0, len_r});

  always_comb begin
    if (wrap) begin
      adv_rail  = rail_r + RAIL_W'(1);
      adv_pos   = ADDR_W'(rail_r) + ADDR_W'(1);
      adv_phase = 1'b0;
    end else begin
      adv_rail  = rail_r;
      adv_pos   = pos_sum[ADDR_W-1:0];
      adv_phase = ~phase_r;
    end
  end

  // config write decode
  always_comb begin
    cfg_rail_nxt = cfg_rail_r;
    cfg_mode_nxt = cfg_mode_r;
    if (cfg_we) begin
      unique case (cfg_index)
        REG_RAIL_COUNT:  cfg_rail_nxt = cfg_data[CFG_RAIL_W-1:0];
        REG_DECODE_MODE: cfg_mode_nxt = cfg_data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_nxt     = state_r;
    rails_nxt     = rails_r;
    mode_nxt      = mode_r;
    len_nxt       = len_r;
    ovf_nxt       = ovf_r;
    n_nxt         = n_r;
    pos_nxt       = pos_r;
    rail_nxt      = rail_r;
    phase_nxt     = phase_r;
    pend_nxt      = issue;
    pend_last_nxt = pend_last_r;
    pend_ovf_nxt  = pend_ovf_r;
    wr_pend_nxt   = 1'b0;
    wr_addr_nxt   = wr_addr_r;
    st_re         = 1'b0;
    st_raddr      = pos_r;
    rb_re         = 1'b0;

    unique case (state_r)
      S_LOAD: begin
        if (in_accept) begin
          len_nxt = st_we ? len_r + LEN_W'(1) : len_r;
          ovf_nxt = ovf_r || !st_we;
          if (in_end_of_line) begin
            rails_nxt = eff_rails;
            mode_nxt  = cfg_mode_r;
            n_nxt     = '0;
            pos_nxt   = '0;
            rail_nxt  = '0;
            phase_nxt = 1'b0;
            state_nxt = cfg_mode_r ? S_PERM : S_EMIT;
          end
        end
      end
      S_PERM: begin
        // read store in arrival order, write to the zigzag position
        st_re       = 1'b1;
        st_raddr    = n_r[ADDR_W-1:0];
        wr_pend_nxt = 1'b1;
        wr_addr_nxt = pos_r;
        pos_nxt     = adv_pos;
        rail_nxt    = adv_rail;
        phase_nxt   = adv_phase;
        n_nxt       = n_r + LEN_W'(1);
        if (at_last) begin
          state_nxt = S_PERMEND;
        end
      end
      S_PERMEND: begin
        n_nxt     = '0;
        pos_nxt   = '0;
        rail_nxt  = '0;
        phase_nxt = 1'b0;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (issue) begin
          st_re         = !mode_r;
          rb_re         = mode_r;
          pos_nxt       = adv_pos;
          rail_nxt      = adv_rail;
          phase_nxt     = adv_phase;
          n_nxt         = n_r + LEN_W'(1);
          pend_last_nxt = at_last;
          pend_ovf_nxt  = ovf_r;
          if (at_last) begin
            len_nxt   = '0;
            ovf_nxt   = 1'b0;
            state_nxt = S_LOAD;
          end
        end
      end
      default: state_nxt = S_LOAD;
    endcase
  end

  // output register, loaded in the cycle after a read is issued
  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_symbol_nxt = out_symbol_r;
    out_last_nxt   = out_last_r;
    out_ovf_nxt    = out_ovf_r;
    if (pend_r) begin
      out_valid_nxt  = 1'b1;
      out_symbol_nxt = mode_r ? rb_rdata : st_rdata;
      out_last_nxt   = pend_last_r;
      out_ovf_nxt    = pend_ovf_r;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_LOAD;
      cfg_rail_r  <= RAIL_RESET;
      cfg_mode_r  <= 1'b0;
      rails_r     <= RAILS_W'(1);
      mode_r      <= 1'b0;
      len_r       <= '0;
      ovf_r       <= 1'b0;
      n_r         <= '0;
      pend_r      <= 1'b0;
      wr_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cfg_rail_r  <= cfg_rail_nxt;
      cfg_mode_r  <= cfg_mode_nxt;
      rails_r     <= rails_nxt;
      mode_r      <= mode_nxt;
      len_r       <= len_nxt;
      ovf_r       <= ovf_nxt;
      n_r         <= n_nxt;
      pend_r      <= pend_nxt;
      wr_pend_r   <= wr_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r        <= pos_nxt;
    rail_r       <= rail_nxt;
    phase_r      <= phase_nxt;
    pend_last_r  <= pend_last_nxt;
    pend_ovf_r   <= pend_ovf_nxt;
    wr_addr_r    <= wr_addr_nxt;
    out_symbol_r <= out_symbol_nxt;
    out_last_r   <= out_last_nxt;
    out_ovf_r    <= out_ovf_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_symbol   = out_symbol_r;
  assign out_last     = out_last_r;
  assign out_overflow = out_ovf_r;

`ifndef SYNTHESIS
  // a landing read never finds the output register occupied
  a_pend_free: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> !out_valid_r)
    else $error("read data landed on a full output register");

  // reorder writes only come from the permute pass
  a_wr_in_perm: assert property (@(posedge clk) disable iff (!rst_n)
    wr_pend_r |-> (state_r == S_PERMEND || state_r == S_PERM))
    else $error("reorder store write outside permute pass");

  // line length bounded by store depth
  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= LEN_W'(MAX_LEN))
    else $error("line length beyond store depth");

  // walker index never passes the line length while reading
  a_n_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PERM || state_r == S_EMIT) |-> (n_r < len_r))
    else $error("read index beyond line length");
`endif

endmodule
